// ----- hw/rtl/lmca_pkg.sv -----
// Shared types and constants for the light and motion change alarm.
`default_nettype none

package lmca_pkg;

    localparam int LUX_W    = 23;
    localparam int MOTION_W = 18;
    localparam int AXIS_W   = 16;
    localparam int TICK_W   = 8;
    localparam int CYCLE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] REG_LUX_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_PHASES  = 2'd3;

    localparam logic [LUX_W-1:0]    LUX_LIMIT_RST    = 23'd30000;
    localparam logic [MOTION_W-1:0] MOTION_LIMIT_RST = 18'd5000;
    localparam logic [TICK_W-1:0]   PHASE_TICKS_RST  = 8'd8;
    localparam logic [CYCLE_W-1:0]  WAIT_PHASES_RST  = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_BUZZ = 2'd1,
        MODE_WAIT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_LIGHT  = 2'd1,
        CAUSE_MOTION = 2'd2
    } cause_t;

    typedef struct packed {
        logic [LUX_W-1:0]    lux_limit;
        logic [MOTION_W-1:0] motion_limit;
        logic [TICK_W-1:0]   phase_ticks;
        logic [CYCLE_W-1:0]  wait_phases;
    } cfg_t;

    typedef struct packed {
        logic [LUX_W-1:0]         lux;
        logic                     lux_valid;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_z;
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic                     motion_valid;
    } sample_t;

    typedef struct packed {
        logic                buzzer_on;
        mode_t               phase;
        logic [CYCLE_W-1:0]  cycle_number;
        cause_t              trigger_cause;
        logic [LUX_W-1:0]    light_change;
        logic [MOTION_W-1:0] motion_change;
        logic                sequence_done;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/light_motion_change_alarm.sv -----
// Top level: configuration registers, input register and the alarm core.
// A result passes through the input register, then the result register; all the
// tick's work sits between the two. Throughput: one item per cycle while the result
// side accepts results; the input register refills as the core takes from it.
// Reset: asynchronous and active low; the alarm is idle and uncalibrated, the
// registers hold their default thresholds and timing, and no item is held.
`default_nettype none

module light_motion_change_alarm
    import lmca_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [LUX_W-1:0]            lux,
    input  logic                        lux_valid,
    input  logic signed [AXIS_W-1:0]    gyro_x,
    input  logic signed [AXIS_W-1:0]    gyro_y,
    input  logic signed [AXIS_W-1:0]    gyro_z,
    input  logic signed [AXIS_W-1:0]    accel_x,
    input  logic signed [AXIS_W-1:0]    accel_y,
    input  logic signed [AXIS_W-1:0]    accel_z,
    input  logic                        motion_valid,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        buzzer_on,
    output logic [1:0]                  phase,
    output logic [CYCLE_W-1:0]          cycle_number,
    output logic [1:0]                  trigger_cause,
    output logic [LUX_W-1:0]            light_change,
    output logic [MOTION_W-1:0]         motion_change,
    output logic                        sequence_done
);

    cfg_t    cfg_reg;
    sample_t sample_reg;
    logic    sample_valid_reg;
    logic    stage_free;
    logic    take;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lux_limit    <= LUX_LIMIT_RST;
            cfg_reg.motion_limit <= MOTION_LIMIT_RST;
            cfg_reg.phase_ticks  <= PHASE_TICKS_RST;
            cfg_reg.wait_phases  <= WAIT_PHASES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LUX_LIMIT:    cfg_reg.lux_limit    <= cfg_data[LUX_W-1:0];
                REG_MOTION_LIMIT: cfg_reg.motion_limit <= cfg_data[MOTION_W-1:0];
                REG_PHASE_TICKS:  cfg_reg.phase_ticks  <= cfg_data[TICK_W-1:0];
                REG_WAIT_PHASES:  cfg_reg.wait_phases  <= cfg_data[CYCLE_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // The core takes the held item whenever its result register can accept one.
    assign take     = sample_valid_reg && stage_free;
    assign in_ready = !sample_valid_reg || stage_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_valid_reg <= 1'b0;
        else if (in_ready)
            sample_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg.lux          <= lux;
            sample_reg.lux_valid    <= lux_valid;
            sample_reg.gyro_x       <= gyro_x;
            sample_reg.gyro_y       <= gyro_y;
            sample_reg.gyro_z       <= gyro_z;
            sample_reg.accel_x      <= accel_x;
            sample_reg.accel_y      <= accel_y;
            sample_reg.accel_z      <= accel_z;
            sample_reg.motion_valid <= motion_valid;
        end
    end

    lmca_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .sample     (sample_reg),
        .take       (take),
        .stage_free (stage_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign buzzer_on     = result.buzzer_on;
    assign phase         = result.phase;
    assign cycle_number  = result.cycle_number;
    assign trigger_cause = result.trigger_cause;
    assign light_change  = result.light_change;
    assign motion_change = result.motion_change;
    assign sequence_done = result.sequence_done;

endmodule

`default_nettype wire

// ----- hw/rtl/lmca_motion_sum.sv -----
// Sum of the absolute values of the six motion axes.
`default_nettype none

module lmca_motion_sum
    import lmca_pkg::*;
(
    input  sample_t             sample,
    output logic [MOTION_W-1:0] motion_sum
);

    logic [AXIS_W-1:0] abs_gx, abs_gy, abs_gz, abs_ax, abs_ay, abs_az;

    // The most negative reading gives 32768, which still fits in 16 unsigned bits.
    function automatic logic [AXIS_W-1:0] abs_axis(input logic [AXIS_W-1:0] v);
        abs_axis = v[AXIS_W-1] ? AXIS_W'(~v + 1'b1) : v;
    endfunction

    assign abs_gx = abs_axis(sample.gyro_x);
    assign abs_gy = abs_axis(sample.gyro_y);
    assign abs_gz = abs_axis(sample.gyro_z);
    assign abs_ax = abs_axis(sample.accel_x);
    assign abs_ay = abs_axis(sample.accel_y);
    assign abs_az = abs_axis(sample.accel_z);

    // Six 16-bit magnitudes of at most 32768 sum to at most 196608, inside 18 bits.
    assign motion_sum = MOTION_W'(abs_gx) + MOTION_W'(abs_gy) + MOTION_W'(abs_gz)
                      + MOTION_W'(abs_ax) + MOTION_W'(abs_ay) + MOTION_W'(abs_az);

endmodule

`default_nettype wire

// ----- hw/rtl/lmca_core.sv -----
// Alarm state machine, baselines and the result register.
`default_nettype none

module lmca_core
    import lmca_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  sample_t sample,
    input  logic    take,
    output logic    stage_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result
);

    mode_t               mode_reg, mode_next;
    logic                baseline_set_reg, baseline_set_next;
    logic [LUX_W-1:0]    light_baseline_reg, light_baseline_next;
    logic [MOTION_W-1:0] motion_baseline_reg, motion_baseline_next;
    logic [CYCLE_W-1:0]  cycles_done_reg, cycles_done_next;
    logic [TICK_W-1:0]   phase_timer_reg, phase_timer_next;
    logic                out_valid_reg, out_valid_next;
    result_t             result_reg, result_next;

    logic [MOTION_W-1:0] motion_sum;
    logic [LUX_W-1:0]    cur_lux;
    logic [MOTION_W-1:0] cur_pos;
    logic [LUX_W-1:0]    light_diff;
    logic [MOTION_W-1:0] motion_diff;
    logic [TICK_W:0]     timer_inc;
    logic                phase_end;
    logic                more_waits;
    logic                in_sequence;
    cause_t              cause;

    lmca_motion_sum u_motion_sum (
        .sample     (sample),
        .motion_sum (motion_sum)
    );

    assign cur_lux = sample.lux_valid ? sample.lux : light_baseline_reg;
    assign cur_pos = sample.motion_valid ? motion_sum : motion_baseline_reg;

    assign light_diff  = (light_baseline_reg > cur_lux) ? light_baseline_reg - cur_lux
                                                        : cur_lux - light_baseline_reg;
    assign motion_diff = (motion_baseline_reg > cur_pos) ? motion_baseline_reg - cur_pos
                                                         : cur_pos - motion_baseline_reg;

    // A phase length of zero behaves as one, since the count is compared after the increment.
    assign timer_inc  = {1'b0, phase_timer_reg} + 1'b1;
    assign phase_end  = timer_inc >= {1'b0, cfg.phase_ticks};
    assign more_waits = cycles_done_reg < cfg.wait_phases;
    assign in_sequence = (mode_reg == MODE_BUZZ) || (mode_reg == MODE_WAIT);

    always_comb
    begin
        if (!baseline_set_reg || in_sequence)
            cause = CAUSE_NONE;
        else if (light_diff > cfg.lux_limit)
            cause = CAUSE_LIGHT;
        else if (motion_diff > cfg.motion_limit)
            cause = CAUSE_MOTION;
        else
            cause = CAUSE_NONE;
    end

    // Next state for one tick.
    always_comb
    begin
        mode_next            = mode_reg;
        baseline_set_next    = baseline_set_reg;
        light_baseline_next  = light_baseline_reg;
        motion_baseline_next = motion_baseline_reg;
        cycles_done_next     = cycles_done_reg;
        phase_timer_next     = phase_timer_reg;
        unique case (mode_reg)
            MODE_BUZZ:
            begin
                if (phase_end)
                begin
                    phase_timer_next = '0;
                    if (more_waits)
                        mode_next = MODE_WAIT;
                    else
                    begin
                        mode_next         = MODE_IDLE;
                        baseline_set_next = 1'b0;
                    end
                end
                else
                    phase_timer_next = timer_inc[TICK_W-1:0];
            end
            MODE_WAIT:
            begin
                if (phase_end)
                begin
                    phase_timer_next = '0;
                    cycles_done_next = cycles_done_reg + 1'b1;
                    mode_next        = MODE_BUZZ;
                end
                else
                    phase_timer_next = timer_inc[TICK_W-1:0];
            end
            default:
            begin
                mode_next            = MODE_IDLE;
                light_baseline_next  = cur_lux;
                motion_baseline_next = cur_pos;
                if (!baseline_set_reg)
                begin
                    cycles_done_next  = '0;
                    baseline_set_next = 1'b1;
                end
                else if (cause != CAUSE_NONE)
                begin
                    mode_next        = MODE_BUZZ;
                    phase_timer_next = '0;
                end
            end
        endcase
    end

    // Result fields for one tick.
    always_comb
    begin
        result_next.buzzer_on     = (mode_reg == MODE_BUZZ);
        result_next.phase         = mode_next;
        result_next.cycle_number  = cycles_done_next;
        result_next.trigger_cause = cause;
        result_next.sequence_done = (mode_reg == MODE_BUZZ) && phase_end && !more_waits;
        if (!in_sequence && baseline_set_reg)
        begin
            result_next.light_change  = light_diff;
            result_next.motion_change = motion_diff;
        end
        else
        begin
            result_next.light_change  = '0;
            result_next.motion_change = '0;
        end
    end

    assign stage_free     = !out_valid_reg || out_ready;
    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= MODE_IDLE;
            baseline_set_reg    <= 1'b0;
            light_baseline_reg  <= '0;
            motion_baseline_reg <= '0;
            cycles_done_reg     <= '0;
            phase_timer_reg     <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                mode_reg            <= mode_next;
                baseline_set_reg    <= baseline_set_next;
                light_baseline_reg  <= light_baseline_next;
                motion_baseline_reg <= motion_baseline_next;
                cycles_done_reg     <= cycles_done_next;
                phase_timer_reg     <= phase_timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // A finished sequence must leave the buzz phase for idle.
    a_done_ends_buzz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.sequence_done
        |-> result_reg.buzzer_on && (result_reg.phase == MODE_IDLE))
        else $error("sequence end reported outside a buzz to idle step");

    // A trigger happens on an idle tick and starts the buzz phase.
    a_trigger_starts_buzz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (result_reg.trigger_cause != CAUSE_NONE)
        |-> !result_reg.buzzer_on && (result_reg.phase == MODE_BUZZ))
        else $error("trigger did not start a buzz phase");

    // Calibration is only dropped when the last buzz ends.
    a_recal_after_buzz: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(baseline_set_reg) |-> ($past(mode_reg) == MODE_BUZZ) && (mode_reg == MODE_IDLE))
        else $error("baseline cleared outside the end of a sequence");

    // Changes are only reported on idle ticks; this check covers the buzz phase.
    a_change_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.buzzer_on
        |-> (result_reg.light_change == '0) && (result_reg.motion_change == '0))
        else $error("change reported during a buzz phase");

endmodule

`default_nettype wire

// ----- sim/lmca_checker.sv -----
`timescale 1ns / 100ps
// Checker for the light and motion change alarm: watches both channels, predicts and compares.
module lmca_checker
    import lmca_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,

    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [LUX_W-1:0]            lux,
    input  logic                        lux_valid,
    input  logic signed [AXIS_W-1:0]    gyro_x,
    input  logic signed [AXIS_W-1:0]    gyro_y,
    input  logic signed [AXIS_W-1:0]    gyro_z,
    input  logic signed [AXIS_W-1:0]    accel_x,
    input  logic signed [AXIS_W-1:0]    accel_y,
    input  logic signed [AXIS_W-1:0]    accel_z,
    input  logic                        motion_valid,

    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        buzzer_on,
    input  logic [1:0]                  phase,
    input  logic [CYCLE_W-1:0]          cycle_number,
    input  logic [1:0]                  trigger_cause,
    input  logic [LUX_W-1:0]            light_change,
    input  logic [MOTION_W-1:0]         motion_change,
    input  logic                        sequence_done,

    output int                          fail_count,
    output int                          outstanding
);

    localparam int PRINT_LIMIT = 40;

    // Local copy of the configuration registers.
    int light_thr   = int'(LUX_LIMIT_RST);
    int motion_thr  = int'(MOTION_LIMIT_RST);
    int tick_len    = int'(PHASE_TICKS_RST);
    int wait_count  = int'(WAIT_PHASES_RST);

    // Local copy of the alarm state.
    mode_t alarm_mode  = MODE_IDLE;
    bit    calibrated  = 1'b0;
    int    light_base  = 0;
    int    motion_base = 0;
    int    cycles_seen = 0;
    int    tick_timer  = 0;

    result_t expected_ticks[$];
    sample_t tick;
    result_t want;
    result_t fresh;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("lmca_checker: %s", msg);
    endtask

    function automatic int axis_mag(input logic signed [AXIS_W-1:0] v);
        int x;
        x = v;
        return (x < 0) ? -x : x;
    endfunction

    // Advances the predicted alarm by one sampling tick and returns its result.
    task automatic step_alarm(input sample_t s, output result_t r);
        int next_t;
        int cur_lux;
        int cur_motion;
        int lchg;
        int mchg;
        r = '0;
        r.trigger_cause = CAUSE_NONE;
        if (alarm_mode == MODE_BUZZ || alarm_mode == MODE_WAIT)
        begin
            next_t = tick_timer + 1;
            r.buzzer_on = (alarm_mode == MODE_BUZZ);
            // A phase length of zero ends the phase on its first tick, like one.
            if (next_t >= tick_len)
            begin
                tick_timer = 0;
                if (alarm_mode == MODE_BUZZ)
                begin
                    if (cycles_seen < wait_count)
                        alarm_mode = MODE_WAIT;
                    else
                    begin
                        alarm_mode = MODE_IDLE;
                        calibrated = 1'b0;
                        r.sequence_done = 1'b1;
                    end
                end
                else
                begin
                    cycles_seen = (cycles_seen + 1) & 7;
                    alarm_mode = MODE_BUZZ;
                end
            end
            else
                tick_timer = next_t & 255;
        end
        else
        begin
            alarm_mode = MODE_IDLE;
            cur_lux = s.lux_valid ? int'(s.lux) : light_base;
            if (s.motion_valid)
                cur_motion = axis_mag(s.gyro_x) + axis_mag(s.gyro_y) + axis_mag(s.gyro_z)
                           + axis_mag(s.accel_x) + axis_mag(s.accel_y) + axis_mag(s.accel_z);
            else
                cur_motion = motion_base;
            if (!calibrated)
            begin
                cycles_seen = 0;
                calibrated = 1'b1;
            end
            else
            begin
                lchg = (light_base > cur_lux) ? light_base - cur_lux : cur_lux - light_base;
                mchg = (motion_base > cur_motion) ? motion_base - cur_motion
                                                  : cur_motion - motion_base;
                r.light_change  = lchg[LUX_W-1:0];
                r.motion_change = mchg[MOTION_W-1:0];
                // Light is checked first, so it wins when both thresholds are exceeded.
                if (lchg > light_thr)
                    r.trigger_cause = CAUSE_LIGHT;
                else if (mchg > motion_thr)
                    r.trigger_cause = CAUSE_MOTION;
                if (r.trigger_cause != CAUSE_NONE)
                begin
                    alarm_mode = MODE_BUZZ;
                    tick_timer = 0;
                end
            end
            light_base  = cur_lux;
            motion_base = cur_motion & ((1 << MOTION_W) - 1);
        end
        r.phase = alarm_mode;
        r.cycle_number = cycles_seen[CYCLE_W-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_thr   = int'(LUX_LIMIT_RST);
            motion_thr  = int'(MOTION_LIMIT_RST);
            tick_len    = int'(PHASE_TICKS_RST);
            wait_count  = int'(WAIT_PHASES_RST);
            alarm_mode  = MODE_IDLE;
            calibrated  = 1'b0;
            light_base  = 0;
            motion_base = 0;
            cycles_seen = 0;
            tick_timer  = 0;
            expected_ticks.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LUX_LIMIT:    light_thr  = int'(cfg_data[LUX_W-1:0]);
                    REG_MOTION_LIMIT: motion_thr = int'(cfg_data[MOTION_W-1:0]);
                    REG_PHASE_TICKS:  tick_len   = int'(cfg_data[TICK_W-1:0]);
                    REG_WAIT_PHASES:  wait_count = int'(cfg_data[CYCLE_W-1:0]);
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                tick.lux          = lux;
                tick.lux_valid    = lux_valid;
                tick.gyro_x       = gyro_x;
                tick.gyro_y       = gyro_y;
                tick.gyro_z       = gyro_z;
                tick.accel_x      = accel_x;
                tick.accel_y      = accel_y;
                tick.accel_z      = accel_z;
                tick.motion_valid = motion_valid;
                step_alarm(tick, fresh);
                expected_ticks.push_back(fresh);
            end
            if (out_valid && out_ready)
            begin
                if (expected_ticks.size() == 0)
                    report("result arrived with no item waiting for it");
                else
                begin
                    want = expected_ticks.pop_front();
                    if (buzzer_on !== want.buzzer_on)
                        report($sformatf("buzzer_on got %0d expected %0d",
                                         buzzer_on, want.buzzer_on));
                    if (phase !== want.phase)
                        report($sformatf("phase got %0d expected %0d", phase, want.phase));
                    if (cycle_number !== want.cycle_number)
                        report($sformatf("cycle_number got %0d expected %0d",
                                         cycle_number, want.cycle_number));
                    if (trigger_cause !== want.trigger_cause)
                        report($sformatf("trigger_cause got %0d expected %0d",
                                         trigger_cause, want.trigger_cause));
                    if (light_change !== want.light_change)
                        report($sformatf("light_change got %0d expected %0d",
                                         light_change, want.light_change));
                    if (motion_change !== want.motion_change)
                        report($sformatf("motion_change got %0d expected %0d",
                                         motion_change, want.motion_change));
                    if (sequence_done !== want.sequence_done)
                        report($sformatf("sequence_done got %0d expected %0d",
                                         sequence_done, want.sequence_done));
                end
            end
        end
        outstanding = expected_ticks.size();
    end

endmodule

// ----- sim/tb_light_motion_change_alarm.sv -----
`timescale 1ns / 100ps
// Testbench top for the light and motion change alarm: stimulus, register writes and verdict.
module tb_light_motion_change_alarm;
    import lmca_pkg::*;

    localparam int LUX_MAX       = (1 << LUX_W) - 1;
    localparam int MOTION_MAX    = (1 << MOTION_W) - 1;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_GAP       = 12;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [LUX_W-1:0]         lux;
    logic                     lux_valid;
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic                     motion_valid;
    logic                     out_valid;
    logic                     out_ready;
    logic                     buzzer_on;
    logic [1:0]               phase;
    logic [CYCLE_W-1:0]       cycle_number;
    logic [1:0]               trigger_cause;
    logic [LUX_W-1:0]         light_change;
    logic [MOTION_W-1:0]      motion_change;
    logic                     sequence_done;

    int fail_count;
    int outstanding;

    bit steady       = 1'b0;
    bit hold_request = 1'b0;
    int scene_lux    = 1000000;

    light_motion_change_alarm DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .lux           (lux),
        .lux_valid     (lux_valid),
        .gyro_x        (gyro_x),
        .gyro_y        (gyro_y),
        .gyro_z        (gyro_z),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .motion_valid  (motion_valid),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .buzzer_on     (buzzer_on),
        .phase         (phase),
        .cycle_number  (cycle_number),
        .trigger_cause (trigger_cause),
        .light_change  (light_change),
        .motion_change (motion_change),
        .sequence_done (sequence_done)
    );

    lmca_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .lux           (lux),
        .lux_valid     (lux_valid),
        .gyro_x        (gyro_x),
        .gyro_y        (gyro_y),
        .gyro_z        (gyro_z),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .motion_valid  (motion_valid),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .buzzer_on     (buzzer_on),
        .phase         (phase),
        .cycle_number  (cycle_number),
        .trigger_cause (trigger_cause),
        .light_change  (light_change),
        .motion_change (motion_change),
        .sequence_done (sequence_done),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic sample_t pack_tick(input int l, input bit lv, input int g, input int a,
                                          input bit mv);
        sample_t s;
        s.lux          = l[LUX_W-1:0];
        s.lux_valid    = lv;
        s.gyro_x       = g[AXIS_W-1:0];
        s.gyro_y       = g[AXIS_W-1:0];
        s.gyro_z       = g[AXIS_W-1:0];
        s.accel_x      = a[AXIS_W-1:0];
        s.accel_y      = a[AXIS_W-1:0];
        s.accel_z      = a[AXIS_W-1:0];
        s.motion_valid = mv;
        return s;
    endfunction

    function automatic logic signed [AXIS_W-1:0] random_axis(input bit big, input int spread);
        int v;
        if (big)
            v = $urandom;
        else
        begin
            v = $urandom_range(2 * spread);
            v = v - spread;
        end
        return v[AXIS_W-1:0];
    endfunction

    // Mostly a steady scene with small noise, now and then a jump in light, a hard
    // shake, or a tick of wholly random bits.
    function automatic sample_t random_tick(input int lux_spread, input int axis_spread);
        sample_t s;
        int pick;
        int level;
        int noise;
        bit shake;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            s.lux          = LUX_W'($urandom);
            s.lux_valid    = 1'($urandom);
            s.gyro_x       = AXIS_W'($urandom);
            s.gyro_y       = AXIS_W'($urandom);
            s.gyro_z       = AXIS_W'($urandom);
            s.accel_x      = AXIS_W'($urandom);
            s.accel_y      = AXIS_W'($urandom);
            s.accel_z      = AXIS_W'($urandom);
            s.motion_valid = 1'($urandom);
        end
        else
        begin
            if (pick < 18)
                scene_lux = $urandom_range(LUX_MAX);
            noise = $urandom_range(2 * lux_spread);
            level = scene_lux + noise - lux_spread;
            if (level < 0)
                level = 0;
            if (level > LUX_MAX)
                level = LUX_MAX;
            shake          = (pick < 28);
            s.lux          = level[LUX_W-1:0];
            s.lux_valid    = ($urandom_range(9) != 0);
            s.gyro_x       = random_axis(shake, axis_spread);
            s.gyro_y       = random_axis(shake, axis_spread);
            s.gyro_z       = random_axis(shake, axis_spread);
            s.accel_x      = random_axis(shake, axis_spread);
            s.accel_y      = random_axis(shake, axis_spread);
            s.accel_z      = random_axis(shake, axis_spread);
            s.motion_valid = ($urandom_range(9) != 0);
        end
        return s;
    endfunction

    function automatic int sender_gap();
        int g;
        g = 0;
        if (!steady)
            while ($urandom_range(99) < 25 && g < MAX_GAP)
                g++;
        return g;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic push_sample(input sample_t s);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        lux          <= s.lux;
        lux_valid    <= s.lux_valid;
        gyro_x       <= s.gyro_x;
        gyro_y       <= s.gyro_y;
        gyro_z       <= s.gyro_z;
        accel_x      <= s.accel_x;
        accel_y      <= s.accel_y;
        accel_z      <= s.accel_z;
        motion_valid <= s.motion_valid;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops offering items and waits until every expected result has come out.
    task automatic settle();
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
    endtask

    task automatic program_alarm(input int lt, input int mt, input int pt, input int wp);
        write_reg(REG_LUX_LIMIT, lt);
        write_reg(REG_MOTION_LIMIT, mt);
        write_reg(REG_PHASE_TICKS, pt);
        write_reg(REG_WAIT_PHASES, wp);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int lt, input int mt, input int pt, input int wp,
                             input int count, input int lux_spread, input int axis_spread,
                             input int hold_at, input int pause_at, input int steady_upto);
        int k;
        settle();
        program_alarm(lt, mt, pt, wp);
        for (k = 0; k < count; k++)
        begin
            steady = (k < steady_upto);
            if (k == hold_at)
                hold_request = 1'b1;
            if (k == pause_at)
                settle();
            push_sample(random_tick(lux_spread, axis_spread));
        end
        steady = 1'b0;
    endtask

    // Result side: random back-pressure, plus one long hold-off when asked for.
    initial
    begin : result_sink
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= steady || ($urandom_range(99) >= 25);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        lux          = '0;
        lux_valid    = 1'b0;
        gyro_x       = '0;
        gyro_y       = '0;
        gyro_z       = '0;
        accel_x      = '0;
        accel_y      = '0;
        accel_z      = '0;
        motion_valid = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Short sequences: one buzz, one wait, one final buzz.
        program_alarm(1000, 600, 1, 1);
        push_sample(pack_tick(0, 1'b1, 0, 0, 1'b1));
        push_sample(pack_tick(LUX_MAX, 1'b1, 0, 0, 1'b1));
        push_sample(pack_tick(0, 1'b0, 0, 0, 1'b0));
        push_sample(pack_tick(0, 1'b0, 0, 0, 1'b0));
        push_sample(pack_tick(0, 1'b0, 0, 0, 1'b0));
        // Recalibrate at the largest motion sum, then swing to the opposite extreme.
        push_sample(pack_tick(LUX_MAX, 1'b1, -32768, -32768, 1'b1));
        push_sample(pack_tick(LUX_MAX, 1'b1, 32767, 32767, 1'b1));
        // An invalid light reading falls back to the baseline; motion triggers.
        push_sample(pack_tick(0, 1'b0, 0, 0, 1'b1));
        push_sample(pack_tick(12345, 1'b1, -5, 5, 1'b1));
        push_sample(pack_tick(12345, 1'b1, -5, 5, 1'b1));
        push_sample(pack_tick(12345, 1'b1, -5, 5, 1'b1));
        // Calibration with both groups invalid keeps the old baselines.
        push_sample(pack_tick(5, 1'b0, 7, 7, 1'b0));
        // A change equal to the threshold does not trigger.
        push_sample(pack_tick(LUX_MAX - 1000, 1'b1, 0, 0, 1'b0));
        // Both thresholds exceeded: light is reported.
        push_sample(pack_tick(LUX_MAX - 2001, 1'b1, 32767, 32767, 1'b1));
        push_sample(pack_tick(1, 1'b1, 1, -1, 1'b1));
        push_sample(pack_tick(1, 1'b1, 1, -1, 1'b1));
        push_sample(pack_tick(1, 1'b1, 1, -1, 1'b1));
        push_sample(pack_tick(100, 1'b1, 100, 100, 1'b1));
        push_sample(pack_tick(100, 1'b1, -200, -200, 1'b1));
        push_sample(pack_tick(100, 1'b1, -200, -201, 1'b1));
        push_sample(pack_tick(100, 1'b1, 0, 0, 1'b1));
        push_sample(pack_tick(LUX_MAX, 1'b0, 0, 0, 1'b0));
        push_sample(pack_tick(LUX_MAX, 1'b0, 0, 0, 1'b0));
        push_sample(pack_tick(LUX_MAX, 1'b0, 0, 0, 1'b0));

        // Zero thresholds and a zero phase length: nearly every calibrated idle tick triggers.
        run_phase(0, 0, 0, 0, 120, 3000, 800, -1, -1, 0);
        // Largest thresholds: nothing can trigger.
        run_phase(LUX_MAX, MOTION_MAX, 255, 7, 100, 3000, 800, -1, -1, 0);
        // Default settings, with a long hold-off on the result side.
        run_phase(int'(LUX_LIMIT_RST), int'(MOTION_LIMIT_RST),
                  int'(PHASE_TICKS_RST), int'(WAIT_PHASES_RST), 250, 3000, 800,
                  100, -1, 0);
        run_phase(2000, 1500, 3, 2, 300, 3000, 800, -1, 250, 150);
        // Longest phases.
        run_phase(500, 300, 255, 0, 200, 3000, 800, -1, -1, 0);
        run_phase($urandom_range(20000), $urandom_range(5000), $urandom_range(6, 1),
                  $urandom_range(7), 250, 3000, 800, -1, -1, 0);

        settle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
